// ===== rtl/saob_pkg.sv =====
// saob_pkg: shared constants of the straight alpha over blend pipeline
// used by saob_front, saob_alpha_lane and straight_alpha_over_blend
`default_nettype none

package saob_pkg;

    // number of colour lanes working side by side (red, green, blue)
    localparam int unsigned COLOR_LANES = 3;

    // register stages in front of the divider in each colour lane
    localparam int unsigned PRE_DIV_STAGES = 2;

    // register stages of the alpha rounding path before its delay line
    localparam int unsigned ALPHA_CALC_STAGES = 2;

endpackage

`default_nettype wire

// ===== rtl/straight_alpha_over_blend.sv =====
// straight_alpha_over_blend: porter-duff over of two straight alpha rgba pixels
// depends on saob_pkg, saob_front, saob_color_lane, saob_alpha_lane
//
//  port group   | dir | tdata fields, lowest bits first
//  s_axis_*     | in  | top r, g, b, a, bottom r, g, b, a (CHANNEL_BITS each)
//  m_axis_*     | out | out r, g, b, a (CHANNEL_BITS each), zero padded to bytes
//
// one item per clock while m_axis_tready stays high; the pipeline depth follows
// CHANNEL_BITS through the one quotient bit per stage divider in each colour lane
// rst_n clears the valid bits and the skid full flag; the data registers are not reset
// s_axis_tready comes from a register: an input skid stage holds one item while
// the pipeline is stalled by m_axis_tready
`default_nettype none

module straight_alpha_over_blend #(
    parameter int unsigned CHANNEL_BITS = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // top_red, top_green, top_blue, top_alpha,
    // bottom_red, bottom_green, bottom_blue, bottom_alpha
    input  wire logic [8*CHANNEL_BITS-1:0]              s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // out_red, out_green, out_blue, out_alpha, zero padding
    output logic      [((4*CHANNEL_BITS+7)/8)*8-1:0]    m_axis_tdata
);

    localparam int unsigned N     = CHANNEL_BITS;
    localparam int unsigned WW    = 2 * N;
    localparam int unsigned IN_W  = 8 * N;
    localparam int unsigned RES_W = 4 * N;
    localparam int unsigned OUT_W = ((4 * N + 7) / 8) * 8;
    localparam int unsigned LANES = saob_pkg::COLOR_LANES;
    localparam int unsigned LAT   = 1 + saob_pkg::PRE_DIV_STAGES + N;

    logic            en;
    logic            skid_full_reg;
    logic            skid_full_next;
    logic [IN_W-1:0] skid_data_reg;
    logic            in_valid;
    logic [IN_W-1:0] in_data;

    logic            vld_reg [LAT];
    logic            out_valid_reg;
    logic [RES_W-1:0] out_data_reg;

    // pipeline moves when the output register is free or being drained
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !skid_full_reg;
    assign in_valid      = skid_full_reg || s_axis_tvalid;
    assign in_data       = skid_full_reg ? skid_data_reg : s_axis_tdata;

    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (en)
        begin
            skid_full_next = 1'b0;
        end
        else if (s_axis_tvalid && !skid_full_reg)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && !en)
        begin
            skid_data_reg <= s_axis_tdata;
        end
    end

    // unpack the input item
    logic [N-1:0] top_color    [LANES];
    logic [N-1:0] bottom_color [LANES];
    logic [N-1:0] top_alpha;
    logic [N-1:0] bottom_alpha;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            top_color[i]    = in_data[i*N +: N];
            bottom_color[i] = in_data[(i+4)*N +: N];
        end
        top_alpha    = in_data[3*N +: N];
        bottom_alpha = in_data[7*N +: N];
    end

    logic [N-1:0]  top_color_f    [LANES];
    logic [N-1:0]  bottom_color_f [LANES];
    logic [WW-1:0] top_scaled_f;
    logic [WW-1:0] bottom_scaled_f;
    logic [WW-1:0] weight_f;

    saob_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk               (clk),
        .en                (en),
        .top_color         (top_color),
        .bottom_color      (bottom_color),
        .top_alpha         (top_alpha),
        .bottom_alpha      (bottom_alpha),
        .top_color_reg     (top_color_f),
        .bottom_color_reg  (bottom_color_f),
        .top_scaled_reg    (top_scaled_f),
        .bottom_scaled_reg (bottom_scaled_f),
        .weight_reg        (weight_f)
    );

    logic [N-1:0] lane_color [LANES];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        saob_color_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_color_lane (
            .clk           (clk),
            .en            (en),
            .top_color     (top_color_f[g]),
            .bottom_color  (bottom_color_f[g]),
            .top_scaled    (top_scaled_f),
            .bottom_scaled (bottom_scaled_f),
            .weight        (weight_f),
            .color         (lane_color[g])
        );
    end

    logic [N-1:0] lane_alpha;
    logic         zero_weight;

    saob_alpha_lane #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_alpha_lane (
        .clk         (clk),
        .en          (en),
        .weight      (weight_f),
        .alpha       (lane_alpha),
        .zero_weight (zero_weight)
    );

    // merge: both pixels transparent gives an all zero result
    logic [RES_W-1:0] merged;

    always_comb
    begin
        merged = {lane_alpha, lane_color[2], lane_color[1], lane_color[0]};
        if (zero_weight)
        begin
            merged = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= merged;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

endmodule

`default_nettype wire

// ===== rtl/saob_front.sv =====
// saob_front: first pipeline stage, forms the blend weight and the shared alpha terms
// depends on saob_pkg
`default_nettype none

module saob_front #(
    parameter int unsigned CHANNEL_BITS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [CHANNEL_BITS-1:0]     top_color [saob_pkg::COLOR_LANES],
    input  wire logic [CHANNEL_BITS-1:0]     bottom_color [saob_pkg::COLOR_LANES],
    input  wire logic [CHANNEL_BITS-1:0]     top_alpha,
    input  wire logic [CHANNEL_BITS-1:0]     bottom_alpha,
    output logic      [CHANNEL_BITS-1:0]     top_color_reg [saob_pkg::COLOR_LANES],
    output logic      [CHANNEL_BITS-1:0]     bottom_color_reg [saob_pkg::COLOR_LANES],
    output logic      [2*CHANNEL_BITS-1:0]   top_scaled_reg,
    output logic      [2*CHANNEL_BITS-1:0]   bottom_scaled_reg,
    output logic      [2*CHANNEL_BITS-1:0]   weight_reg
);

    localparam int unsigned N  = CHANNEL_BITS;
    localparam int unsigned WW = 2 * N;
    localparam logic [N-1:0] CH_MAX = '1;

    logic [N-1:0]  top_inv;
    logic [WW-1:0] top_scaled_next;
    logic [WW-1:0] bottom_scaled_next;
    logic [WW-1:0] weight_next;

    // ta * max as a shift and subtract
    assign top_scaled_next    = {top_alpha, {N{1'b0}}} - WW'(top_alpha);
    assign top_inv            = CH_MAX - top_alpha;
    assign bottom_scaled_next = WW'(bottom_alpha) * WW'(top_inv);
    assign weight_next        = top_scaled_next + bottom_scaled_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_color_reg     <= top_color;
            bottom_color_reg  <= bottom_color;
            top_scaled_reg    <= top_scaled_next;
            bottom_scaled_reg <= bottom_scaled_next;
            weight_reg        <= weight_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/saob_color_lane.sv =====
// saob_color_lane: one colour channel, weighted sum and a one bit per stage restoring divider
// uses nothing from saob_pkg; the top level latency sum assumes its stage layout
`default_nettype none

module saob_color_lane #(
    parameter int unsigned CHANNEL_BITS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [CHANNEL_BITS-1:0]     top_color,
    input  wire logic [CHANNEL_BITS-1:0]     bottom_color,
    input  wire logic [2*CHANNEL_BITS-1:0]   top_scaled,
    input  wire logic [2*CHANNEL_BITS-1:0]   bottom_scaled,
    input  wire logic [2*CHANNEL_BITS-1:0]   weight,
    output logic      [CHANNEL_BITS-1:0]     color
);

    localparam int unsigned N  = CHANNEL_BITS;
    localparam int unsigned WW = 2 * N;
    localparam int unsigned PW = 3 * N;
    localparam int unsigned SW = 3 * N + 1;
    localparam int unsigned DW = 3 * N + 2;
    localparam int unsigned RW = 2 * N + 1;

    // product stage
    logic [PW-1:0] prod_top_reg;
    logic [PW-1:0] prod_bottom_reg;
    logic [WW-1:0] weight_a_reg;

    logic [PW-1:0] prod_top_next;
    logic [PW-1:0] prod_bottom_next;

    assign prod_top_next    = PW'(top_color) * PW'(top_scaled);
    assign prod_bottom_next = PW'(bottom_color) * PW'(bottom_scaled);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_top_reg    <= prod_top_next;
            prod_bottom_reg <= prod_bottom_next;
            weight_a_reg    <= weight;
        end
    end

    // dividend 2*num + w over divisor 2*w, quotient known to fit in N bits
    logic [SW-1:0] num_sum;
    logic [DW-1:0] dividend;

    assign num_sum  = SW'(prod_top_reg) + SW'(prod_bottom_reg);
    assign dividend = {num_sum, 1'b0} + DW'(weight_a_reg);

    logic [RW-1:0] rem_reg  [N];
    logic [N-1:0]  low_reg  [N];
    logic [RW-1:0] div_reg  [N];
    logic [N-1:0]  quot_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= dividend[N+RW-1:N];
            low_reg[0] <= dividend[N-1:0];
            div_reg[0] <= {weight_a_reg, 1'b0};
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_div
        logic [RW:0]   trial;
        logic [RW:0]   diff;
        logic          take;
        logic [RW-1:0] rem_next;
        logic [N-1:0]  quot_in;

        assign trial    = {rem_reg[k], low_reg[k][N-1]};
        assign diff     = trial - {1'b0, div_reg[k]};
        assign take     = (trial >= {1'b0, div_reg[k]});
        assign rem_next = take ? diff[RW-1:0] : trial[RW-1:0];

        if (k == 0)
        begin : g_first
            assign quot_in = '0;
        end
        else
        begin : g_rest
            assign quot_in = quot_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quot_reg[k] <= {quot_in[N-2:0], take};
            end
        end

        if (k < N - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= rem_next;
                    low_reg[k+1] <= {low_reg[k][N-2:0], 1'b0};
                    div_reg[k+1] <= div_reg[k];
                end
            end
        end
    end

    assign color = quot_reg[N-1];

endmodule

`default_nettype wire

// ===== rtl/saob_alpha_lane.sv =====
// saob_alpha_lane: out alpha as round half up of w / max, plus the zero weight flag
// depends on saob_pkg
`default_nettype none

module saob_alpha_lane #(
    parameter int unsigned CHANNEL_BITS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [2*CHANNEL_BITS-1:0]   weight,
    output logic      [CHANNEL_BITS-1:0]     alpha,
    output logic                             zero_weight
);

    localparam int unsigned N   = CHANNEL_BITS;
    localparam int unsigned WW  = 2 * N;
    localparam int unsigned XW  = 2 * N + 1;
    localparam int unsigned DLY = saob_pkg::PRE_DIV_STAGES + N - saob_pkg::ALPHA_CALC_STAGES;
    localparam logic [WW-1:0] HALF   = WW'((1 << (N - 1)) - 1);
    localparam logic [XW-1:0] CH_MAX = XW'((1 << N) - 1);

    // estimate stage: floor((w + half) / max) from below, off by at most one
    logic [WW-1:0] x_val;
    logic [XW-1:0] est_sum;

    logic [WW-1:0] x_reg;
    logic [N:0]    est_reg;
    logic          zero_a_reg;

    assign x_val   = weight + HALF;
    assign est_sum = XW'(x_val) + XW'(x_val >> N);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= x_val;
            est_reg    <= est_sum[XW-1:N];
            zero_a_reg <= (weight == '0);
        end
    end

    // correction stage
    logic [XW-1:0] est_times_max;
    logic [XW-1:0] rem_val;
    logic [N:0]    est_fixed;

    logic [N-1:0]  alpha_b_reg;
    logic          zero_b_reg;

    assign est_times_max = {est_reg, {N{1'b0}}} - XW'(est_reg);
    assign rem_val       = XW'(x_reg) - est_times_max;
    assign est_fixed     = (rem_val >= CH_MAX) ? est_reg + 1'b1 : est_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_b_reg <= est_fixed[N-1:0];
            zero_b_reg  <= zero_a_reg;
        end
    end

    // delay line to line up with the colour lanes
    logic [N-1:0] alpha_dly_reg [DLY];
    logic         zero_dly_reg  [DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alpha_dly_reg[0] <= alpha_b_reg;
            zero_dly_reg[0]  <= zero_b_reg;
            for (int i = 1; i < DLY; i++)
            begin
                alpha_dly_reg[i] <= alpha_dly_reg[i-1];
                zero_dly_reg[i]  <= zero_dly_reg[i-1];
            end
        end
    end

    assign alpha       = alpha_dly_reg[DLY-1];
    assign zero_weight = zero_dly_reg[DLY-1];

endmodule

`default_nettype wire
